>>> rtl/bdhr_pkg.sv
`timescale 1ns / 1ps
// Package for the button debounce / hold / auto-repeat block.
// Shared constants, register indexes and the per-button state type. No dependencies.
package bdhr_pkg;

  localparam int NUM_BUTTONS = 5;
  localparam int BTN_IDX_W   = $clog2(NUM_BUTTONS);
  localparam int TIME_W      = 32;
  localparam int MS_W        = 16;
  localparam int CODE_W      = 3;

  // event code for a hold event; button events use the button index
  localparam logic [CODE_W-1:0] HOLD_CODE = 3'd5;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MASK  = 3'd4;

  localparam logic [MS_W-1:0]        DEBOUNCE_RST     = 16'd250;
  localparam logic [MS_W-1:0]        HOLD_RST         = 16'd2000;
  localparam logic [MS_W-1:0]        REPEAT_START_RST = 16'd800;
  localparam logic [MS_W-1:0]        REPEAT_PER_RST   = 16'd250;
  localparam logic [NUM_BUTTONS-1:0] REPEAT_MASK_RST  = 5'd30;

  typedef struct packed {
    logic [MS_W-1:0]        debounce_ms;
    logic [MS_W-1:0]        hold_ms;
    logic [MS_W-1:0]        repeat_start_ms;
    logic [MS_W-1:0]        repeat_period_ms;
    logic [NUM_BUTTONS-1:0] repeat_mask;
  } cfg_t;

  typedef struct packed {
    logic              last_level;
    logic              hold_sent;
    logic [TIME_W-1:0] press_time;
    logic [TIME_W-1:0] last_repeat_time;
  } btn_state_t;

  localparam btn_state_t BTN_STATE_RST = '{
    last_level:       1'b1,
    hold_sent:        1'b0,
    press_time:       '0,
    last_repeat_time: '0
  };

endpackage

>>> rtl/bdhr_cfg.sv
`timescale 1ns / 1ps
// APB-style configuration registers for the button block.
// Depends on bdhr_pkg.
module bdhr_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bdhr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [bdhr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bdhr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output bdhr_pkg::cfg_t                    cfg
);

  bdhr_pkg::cfg_t                   cfg_r;
  logic [bdhr_pkg::CFG_IDX_W-1:0]   idx;
  logic                             wr;

  assign pready = 1'b1;
  assign idx    = paddr[bdhr_pkg::CFG_ADDR_W-1:2];
  assign wr     = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms      <= bdhr_pkg::DEBOUNCE_RST;
      cfg_r.hold_ms          <= bdhr_pkg::HOLD_RST;
      cfg_r.repeat_start_ms  <= bdhr_pkg::REPEAT_START_RST;
      cfg_r.repeat_period_ms <= bdhr_pkg::REPEAT_PER_RST;
      cfg_r.repeat_mask      <= bdhr_pkg::REPEAT_MASK_RST;
    end else if (wr) begin
      case (idx)
        bdhr_pkg::REG_DEBOUNCE:     cfg_r.debounce_ms      <= pwdata[bdhr_pkg::MS_W-1:0];
        bdhr_pkg::REG_HOLD:         cfg_r.hold_ms          <= pwdata[bdhr_pkg::MS_W-1:0];
        bdhr_pkg::REG_REPEAT_START: cfg_r.repeat_start_ms  <= pwdata[bdhr_pkg::MS_W-1:0];
        bdhr_pkg::REG_REPEAT_PER:   cfg_r.repeat_period_ms <= pwdata[bdhr_pkg::MS_W-1:0];
        bdhr_pkg::REG_REPEAT_MASK:  cfg_r.repeat_mask <= pwdata[bdhr_pkg::NUM_BUTTONS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      bdhr_pkg::REG_DEBOUNCE:     prdata[bdhr_pkg::MS_W-1:0] = cfg_r.debounce_ms;
      bdhr_pkg::REG_HOLD:         prdata[bdhr_pkg::MS_W-1:0] = cfg_r.hold_ms;
      bdhr_pkg::REG_REPEAT_START: prdata[bdhr_pkg::MS_W-1:0] = cfg_r.repeat_start_ms;
      bdhr_pkg::REG_REPEAT_PER:   prdata[bdhr_pkg::MS_W-1:0] = cfg_r.repeat_period_ms;
      bdhr_pkg::REG_REPEAT_MASK:  prdata[bdhr_pkg::NUM_BUTTONS-1:0] = cfg_r.repeat_mask;
      default:                    prdata = '0;
    endcase
  end

endmodule

>>> rtl/bdhr_state_mem.sv
`timescale 1ns / 1ps
// Per-button state memory: one entry per button, registered read.
// Entries never written read as the reset state. Depends on bdhr_pkg.
module bdhr_state_mem (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             rd_en,
  input  logic [bdhr_pkg::BTN_IDX_W-1:0]   rd_addr,
  output bdhr_pkg::btn_state_t             rd_data,
  input  logic                             wr_en,
  input  logic [bdhr_pkg::BTN_IDX_W-1:0]   wr_addr,
  input  bdhr_pkg::btn_state_t             wr_data
);

  bdhr_pkg::btn_state_t               mem [bdhr_pkg::NUM_BUTTONS];
  logic [bdhr_pkg::NUM_BUTTONS-1:0]   valid_r;
  bdhr_pkg::btn_state_t               rdata_r;
  logic                               rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : bdhr_pkg::BTN_STATE_RST;

endmodule

>>> rtl/bdhr_seq.sv
`timescale 1ns / 1ps
// Per-item sequencer: walks the buttons through the state memory,
// updates each entry and builds the result run. Depends on bdhr_pkg.
module bdhr_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bdhr_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bdhr_pkg::TIME_W-1:0]      in_time_ms,
  input  logic [bdhr_pkg::NUM_BUTTONS-1:0] in_levels,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_has_event,
  output logic [bdhr_pkg::CODE_W-1:0]      out_event_code,
  output logic                             out_activity,
  output logic                             out_last,
  output logic                             rd_en,
  output logic [bdhr_pkg::BTN_IDX_W-1:0]   rd_addr,
  input  bdhr_pkg::btn_state_t             rd_data,
  output logic                             wr_en,
  output logic [bdhr_pkg::BTN_IDX_W-1:0]   wr_addr,
  output bdhr_pkg::btn_state_t             wr_data
);

  typedef enum logic [1:0] {S_IDLE, S_PROC, S_FLUSH} state_t;

  localparam logic [bdhr_pkg::BTN_IDX_W-1:0] LAST_IDX =
    bdhr_pkg::BTN_IDX_W'(bdhr_pkg::NUM_BUTTONS - 1);

  state_t                             state_r, state_nxt;
  logic [bdhr_pkg::BTN_IDX_W-1:0]     idx_r, idx_nxt;
  logic [bdhr_pkg::TIME_W-1:0]        now_r, now_nxt;
  logic [bdhr_pkg::NUM_BUTTONS-1:0]   levels_r, levels_nxt;
  logic                               act_r, act_nxt;
  logic                               pend_vld_r, pend_vld_nxt;
  logic [bdhr_pkg::CODE_W-1:0]        pend_code_r, pend_code_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_has_event_r, out_has_event_nxt;
  logic [bdhr_pkg::CODE_W-1:0]        out_event_code_r, out_event_code_nxt;
  logic                               out_activity_r, out_activity_nxt;
  logic                               out_last_r, out_last_nxt;

  // per-button evaluation
  bdhr_pkg::btn_state_t               st;
  logic                               lvl, rep, emit, act, press_ok;
  logic [bdhr_pkg::CODE_W-1:0]        code;
  logic [bdhr_pkg::TIME_W-1:0]        since_mark, since_press;
  logic                               out_free, advance, accept;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    st          = rd_data;
    lvl         = levels_r[idx_r];
    rep         = cfg.repeat_mask[idx_r];
    emit        = 1'b0;
    act         = 1'b0;
    code        = '0;
    since_mark  = now_r - rd_data.last_repeat_time;
    since_press = now_r - rd_data.press_time;
    press_ok    = rd_data.last_level && !lvl &&
                  (since_mark > {16'd0, cfg.debounce_ms});
    // an accepted press resets both marks to now, so hold/repeat cannot fire
    if (press_ok) begin
      st.press_time       = now_r;
      st.last_repeat_time = now_r;
      st.hold_sent        = 1'b0;
      act                 = 1'b1;
    end else if (!lvl) begin
      if (!rep && !rd_data.hold_sent && (since_press > {16'd0, cfg.hold_ms})) begin
        st.hold_sent = 1'b1;
        emit         = 1'b1;
        code         = bdhr_pkg::HOLD_CODE;
        act          = 1'b1;
      end
      if (rep && (since_press > {16'd0, cfg.repeat_start_ms}) &&
          (since_mark > {16'd0, cfg.repeat_period_ms})) begin
        st.last_repeat_time = now_r;
        emit                = 1'b1;
        code                = bdhr_pkg::CODE_W'(idx_r);
      end
    end
    if (!rd_data.last_level && lvl) begin
      if (!rd_data.hold_sent) begin
        emit = 1'b1;
        code = bdhr_pkg::CODE_W'(idx_r);
      end
      st.hold_sent = 1'b0;
    end
    st.last_level = lvl;
  end

  // a new event displaces the pending one into the output register
  assign advance = !(emit && pend_vld_r && !out_free);

  always_comb begin
    state_nxt          = state_r;
    idx_nxt            = idx_r;
    now_nxt            = now_r;
    levels_nxt         = levels_r;
    act_nxt            = act_r;
    pend_vld_nxt       = pend_vld_r;
    pend_code_nxt      = pend_code_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_has_event_nxt  = out_has_event_r;
    out_event_code_nxt = out_event_code_r;
    out_activity_nxt   = out_activity_r;
    out_last_nxt       = out_last_r;
    rd_en              = 1'b0;
    rd_addr            = '0;
    wr_en              = 1'b0;
    wr_addr            = idx_r;
    wr_data            = st;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          now_nxt      = in_time_ms;
          levels_nxt   = in_levels;
          act_nxt      = 1'b0;
          pend_vld_nxt = 1'b0;
          idx_nxt      = '0;
          rd_en        = 1'b1;
          state_nxt    = S_PROC;
        end
      end
      S_PROC: begin
        if (advance) begin
          wr_en   = 1'b1;
          act_nxt = act_r | act;
          if (emit) begin
            if (pend_vld_r) begin
              out_valid_nxt      = 1'b1;
              out_has_event_nxt  = 1'b1;
              out_event_code_nxt = pend_code_r;
              out_activity_nxt   = 1'b0;
              out_last_nxt       = 1'b0;
            end
            pend_vld_nxt  = 1'b1;
            pend_code_nxt = code;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt = idx_r + 1'b1;
            rd_en   = 1'b1;
            rd_addr = idx_r + 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_has_event_nxt  = pend_vld_r;
          out_event_code_nxt = pend_vld_r ? pend_code_r : '0;
          out_activity_nxt   = act_r;
          out_last_nxt       = 1'b1;
          pend_vld_nxt       = 1'b0;
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      act_r       <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      act_r       <= act_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    now_r            <= now_nxt;
    levels_r         <= levels_nxt;
    pend_code_r      <= pend_code_nxt;
    out_has_event_r  <= out_has_event_nxt;
    out_event_code_r <= out_event_code_nxt;
    out_activity_r   <= out_activity_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_has_event  = out_has_event_r;
  assign out_event_code = out_event_code_r;
  assign out_activity   = out_activity_r;
  assign out_last       = out_last_r;

  // an empty result is always the closing one of its item
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_has_event_r |-> out_last_r)
    else $error("empty result without last");

  // activity is reported only on the closing result
  a_act_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> !out_activity_r)
    else $error("activity on non-last result");

  // no pending event survives into idle
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_vld_r)
    else $error("pending event left in idle");

  // memory write only ever targets the entry being worked on
  a_wr_in_proc: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_PROC) && (wr_addr <= LAST_IDX))
    else $error("state write outside button walk");

endmodule

>>> rtl/button_debounce_hold_repeat_core.sv
`timescale 1ns / 1ps
// Top level of the button debounce / hold / auto-repeat block.
// Depends on bdhr_pkg, bdhr_cfg, bdhr_state_mem and bdhr_seq.
//
// Usage:
//  - Input channel (in_valid / in_stall): one item per sampling tick, carrying
//    the millisecond time and the active-low levels of the five buttons.
//  - Result channel (out_valid / out_stall): each tick yields one to five
//    results in order; out_last marks the closing one, which also carries
//    out_activity (a press was accepted or a hold sent during the tick).
//    A tick with no event still yields one result with has_event low.
//  - APB-style register port: debounce, hold, repeat start, repeat period
//    and repeat mask. pready is always high; write only while idle.
// Timing:
//  - Per-button state sits in a five-entry memory with registered read.
//    The sequencer reads button i+1 while it updates and writes back
//    button i.
//  - An item passes through an accept step, five button steps and one
//    closing step; in_stall stays high until the closing step is done. An
//    event goes out once a later button emits, or else with the closing step.
//  - A stalled receiver holds the output register; the walk pauses when a new
//    event must push the pending one out, and the closing step waits too.
// Reset: synchronous, active low. Registers return to defaults; all buttons
// read as released with zeroed times through per-entry valid bits.
module button_debounce_hold_repeat_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bdhr_pkg::TIME_W-1:0]      in_time_ms,
  input  logic [bdhr_pkg::NUM_BUTTONS-1:0] in_levels,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_has_event,
  output logic [bdhr_pkg::CODE_W-1:0]      out_event_code,
  output logic                             out_activity,
  output logic                             out_last,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bdhr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [bdhr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [bdhr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  bdhr_pkg::cfg_t                   cfg;
  logic                             rd_en, wr_en;
  logic [bdhr_pkg::BTN_IDX_W-1:0]   rd_addr, wr_addr;
  bdhr_pkg::btn_state_t             rd_data, wr_data;

  bdhr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // per-button state, read ahead of its update through the registered read port
  bdhr_state_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bdhr_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_time_ms     (in_time_ms),
    .in_levels      (in_levels),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_has_event  (out_has_event),
    .out_event_code (out_event_code),
    .out_activity   (out_activity),
    .out_last       (out_last),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data)
  );

endmodule
